// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the top-k list.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, suspended while reset is low.
`define TKSRL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tksrl assertion failed");

// Checked on every rising edge, reset included.
`define TKSRL_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("tksrl assertion failed");

`endif

// ----- design/tksrl_pkg.sv -----
// Types and codes of the top-k sorted result list.
// Used by the top level and its checker; depends on nothing.
package tksrl_pkg;

  localparam int unsigned ScoreW   = 32;
  localparam int unsigned ActionW  = 16;
  localparam int unsigned ReadIdxW = 4;
  localparam int unsigned PosW     = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CapW     = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAPACITY = 4'd0,
    CFG_HIGHER   = 4'd1
  } cfg_reg_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_INSERTED   = 3'd0,
    STAT_DUPLICATE  = 3'd1,
    STAT_NOT_BETTER = 3'd2,
    STAT_READ_OK    = 3'd3,
    STAT_READ_RANGE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [ActionW-1:0]       action;
  } entry_t;

  typedef struct packed {
    cmd_e                     command;
    logic signed [ScoreW-1:0] score;
    logic [ActionW-1:0]       action_id;
    logic [ReadIdxW-1:0]      read_index;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic [PosW-1:0]          position;
    logic [CountW-1:0]        entry_count;
    logic                     evicted;
    logic signed [ScoreW-1:0] entry_score;
    logic [ActionW-1:0]       entry_action;
  } out_t;

endpackage

// ----- design/top_k_sorted_result_list.sv -----
// Top-k sorted result list: entries kept best first in one synchronous RAM.
// Depends on tksrl_pkg.
//
// One beat in, one beat out. A read waits on the RAM only when the index is within the held
// entries. An insert walks the held entries one RAM read per cycle (duplicate check,
// sorted slot, worst entry), then moves the entries below the slot down one place per
// cycle and writes the new one; a rejected insert moves and writes nothing, and an insert
// into an empty list skips the walk. The single RAM read port sets this pace. A finished
// result sits in an output register, so the next beat is taken while it waits; a second
// finished result waits until that register frees up. Writing capacity empties the list
// at once; no clearing pass is needed.
module top_k_sorted_result_list #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tksrl_pkg::in_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tksrl_pkg::out_t                      out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tksrl_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tksrl_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_ENTRIES);
  localparam logic [CntW-1:0] ResetCap = (MAX_ENTRIES < 16) ? CntW'(MAX_ENTRIES) : CntW'(16);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  function automatic logic better(input logic signed [tksrl_pkg::ScoreW-1:0] a,
                                  input logic signed [tksrl_pkg::ScoreW-1:0] b,
                                  input logic hib);
    better = hib ? (a > b) : (a < b);
  endfunction

  tksrl_pkg::entry_t mem_q [MAX_ENTRIES];
  tksrl_pkg::entry_t rdata_q;

  tksrl_pkg::state_e state_q, state_d;
  logic [CntW-1:0]   held_q, held_d;
  logic [CntW-1:0]   cap_q, cap_d;
  logic              hib_q, hib_d;
  tksrl_pkg::in_t    item_q, item_d;
  logic [IdxW-1:0]   scan_idx_q, scan_idx_d;
  logic              rv_q, rv_d;
  logic [IdxW-1:0]   rv_idx_q, rv_idx_d;
  logic              dup_q, dup_d;
  logic [CntW-1:0]   slot_q, slot_d;
  logic signed [tksrl_pkg::ScoreW-1:0] worst_q, worst_d;
  logic [IdxW-1:0]   sh_idx_q, sh_idx_d;
  logic [IdxW-1:0]   slot_fin_q, slot_fin_d;
  logic              shw_vld_q, shw_vld_d;
  logic [IdxW-1:0]   shw_addr_q, shw_addr_d;
  tksrl_pkg::out_t   res_q, res_d;
  logic              out_valid_q, out_valid_d;
  tksrl_pkg::out_t   out_q, out_d;

  logic              in_acc, cfg_acc, in_range, scan_last, full, rej_dup, rej_nb;
  logic              shift_done, new_wr, out_free;
  logic [CntW-1:0]   last, slot_min;
  logic [IdxW-1:0]   raddr, waddr;
  logic              we;
  tksrl_pkg::entry_t wdata;
  logic [tksrl_pkg::CapW-1:0] cap_raw;

  assign in_ready_o  = (state_q == tksrl_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == tksrl_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_range   = (32'(in_data_i.read_index) < 32'(held_q));
  assign scan_last  = (CntW'(scan_idx_q) == (held_q - OneCnt));
  assign full       = (held_q >= cap_q);
  assign rej_dup    = dup_q;
  assign rej_nb     = full && (held_q != '0) && !better(item_q.score, worst_q, hib_q);
  assign last       = full ? (cap_q - OneCnt) : held_q;
  assign slot_min   = (slot_q > last) ? last : slot_q;
  assign shift_done = (sh_idx_q == slot_fin_q);
  assign new_wr     = (state_q == tksrl_pkg::S_SHIFT) && shift_done && !shw_vld_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cap_raw    = cfg_data_i[tksrl_pkg::CapW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tksrl_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == tksrl_pkg::CMD_READ) begin
            state_d = in_range ? tksrl_pkg::S_RD_WAIT : tksrl_pkg::S_DONE;
          end else begin
            state_d = (held_q == '0) ? tksrl_pkg::S_DECIDE : tksrl_pkg::S_SCAN;
          end
        end
      end
      tksrl_pkg::S_RD_WAIT:  state_d = tksrl_pkg::S_DONE;
      tksrl_pkg::S_SCAN: begin
        if (scan_last) state_d = tksrl_pkg::S_SCAN_END;
      end
      tksrl_pkg::S_SCAN_END: state_d = tksrl_pkg::S_DECIDE;
      tksrl_pkg::S_DECIDE: begin
        state_d = (rej_dup || rej_nb) ? tksrl_pkg::S_DONE : tksrl_pkg::S_SHIFT;
      end
      tksrl_pkg::S_SHIFT: begin
        if (new_wr) state_d = tksrl_pkg::S_DONE;
      end
      tksrl_pkg::S_DONE: begin
        if (out_free) state_d = tksrl_pkg::S_IDLE;
      end
      default: state_d = tksrl_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    held_d      = held_q;
    cap_d       = cap_q;
    hib_d       = hib_q;
    item_d      = item_q;
    scan_idx_d  = scan_idx_q;
    rv_d        = 1'b0;
    rv_idx_d    = scan_idx_q;
    dup_d       = dup_q;
    slot_d      = slot_q;
    worst_d     = worst_q;
    sh_idx_d    = sh_idx_q;
    slot_fin_d  = slot_fin_q;
    shw_vld_d   = 1'b0;
    shw_addr_d  = sh_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    raddr       = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    if (cfg_acc) begin
      unique case (cfg_index_i)
        tksrl_pkg::CFG_CAPACITY: begin
          if (cap_raw == '0) begin
            cap_d = OneCnt;
          end else if (32'(cap_raw) > MAX_ENTRIES) begin
            cap_d = MaxCnt;
          end else begin
            cap_d = CntW'(cap_raw);
          end
          held_d = '0;
        end
        tksrl_pkg::CFG_HIGHER: hib_d = cfg_data_i[0];
        default: ;
      endcase
    end

    // scan compare, one entry per cycle behind the RAM read
    if (rv_q) begin
      if ((rdata_q.score == item_q.score) && (rdata_q.action == item_q.action_id)) begin
        dup_d = 1'b1;
      end
      if (!better(item_q.score, rdata_q.score, hib_q)) slot_d = CntW'(rv_idx_q) + OneCnt;
      worst_d = rdata_q.score;
    end

    unique case (state_q)
      tksrl_pkg::S_IDLE: begin
        if (in_acc) begin
          item_d     = in_data_i;
          scan_idx_d = '0;
          dup_d      = 1'b0;
          slot_d     = '0;
          raddr      = IdxW'(in_data_i.read_index);
          res_d.status       = tksrl_pkg::STAT_READ_RANGE;
          res_d.position     = in_data_i.read_index;
          res_d.entry_count  = tksrl_pkg::CountW'(held_q);
          res_d.evicted      = 1'b0;
          res_d.entry_score  = '0;
          res_d.entry_action = '0;
        end
      end
      tksrl_pkg::S_RD_WAIT: begin
        res_d.status       = tksrl_pkg::STAT_READ_OK;
        res_d.entry_score  = rdata_q.score;
        res_d.entry_action = rdata_q.action;
      end
      tksrl_pkg::S_SCAN: begin
        raddr      = scan_idx_q;
        rv_d       = 1'b1;
        rv_idx_d   = scan_idx_q;
        scan_idx_d = scan_idx_q + IdxW'(1);
      end
      tksrl_pkg::S_SCAN_END: ;
      tksrl_pkg::S_DECIDE: begin
        res_d.position     = '0;
        res_d.entry_count  = tksrl_pkg::CountW'(held_q);
        res_d.evicted      = 1'b0;
        res_d.entry_score  = '0;
        res_d.entry_action = '0;
        if (rej_dup) begin
          res_d.status = tksrl_pkg::STAT_DUPLICATE;
        end else if (rej_nb) begin
          res_d.status = tksrl_pkg::STAT_NOT_BETTER;
        end else begin
          held_d            = full ? held_q : (held_q + OneCnt);
          slot_fin_d        = IdxW'(slot_min);
          sh_idx_d          = IdxW'(last);
          res_d.status      = tksrl_pkg::STAT_INSERTED;
          res_d.position    = tksrl_pkg::PosW'(slot_min);
          res_d.entry_count = tksrl_pkg::CountW'(full ? held_q : (held_q + OneCnt));
          res_d.evicted     = full;
        end
      end
      tksrl_pkg::S_SHIFT: begin
        if (!shift_done) begin
          raddr      = sh_idx_q - IdxW'(1);
          shw_vld_d  = 1'b1;
          shw_addr_d = sh_idx_q;
          sh_idx_d   = sh_idx_q - IdxW'(1);
        end
      end
      tksrl_pkg::S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // RAM write: a moved entry lands one slot lower, then the new entry
  assign we    = shw_vld_q || new_wr;
  assign waddr = shw_vld_q ? shw_addr_q : slot_fin_q;
  assign wdata = shw_vld_q ? rdata_q
                           : tksrl_pkg::entry_t'({item_q.score, item_q.action_id});

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tksrl_pkg::S_IDLE;
      held_q      <= '0;
      cap_q       <= ResetCap;
      hib_q       <= 1'b0;
      rv_q        <= 1'b0;
      shw_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      cap_q       <= cap_d;
      hib_q       <= hib_d;
      rv_q        <= rv_d;
      shw_vld_q   <= shw_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    scan_idx_q <= scan_idx_d;
    rv_idx_q   <= rv_idx_d;
    dup_q      <= dup_d;
    slot_q     <= slot_d;
    worst_q    <= worst_d;
    sh_idx_q   <= sh_idx_d;
    slot_fin_q <= slot_fin_d;
    shw_addr_q <= shw_addr_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

// ----- design/tksrl_checker.sv -----
// Port-level checks of the top-k sorted result list, bound to the top level.
// Depends on tksrl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tksrl_checker #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input tksrl_pkg::out_t out_data_o
);

  `TKSRL_ASSERT(a_count_bound, clk_i, rst_ni, out_valid_o |-> (32'(out_data_o.entry_count) <= MAX_ENTRIES))
  `TKSRL_ASSERT(a_evict_on_insert, clk_i, rst_ni, (out_valid_o && out_data_o.evicted) |-> (out_data_o.status == tksrl_pkg::STAT_INSERTED))
  `TKSRL_ASSERT(a_entry_zero, clk_i, rst_ni, (out_valid_o && (out_data_o.status != tksrl_pkg::STAT_READ_OK)) |-> ((out_data_o.entry_score == '0) && (out_data_o.entry_action == '0)))
  `TKSRL_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))

endmodule

bind top_k_sorted_result_list tksrl_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_tksrl_checker (.*);
